// File: rtl/hrvtds_pkg.sv
`default_nettype none
package hrvtds_pkg;

   localparam int MAX_SAMPLES = 65536;
   localparam int SAMPLE_W = 16;
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = SAMPLE_W + $clog2(MAX_SAMPLES);
   localparam int SQ_W = 2 * SAMPLE_W + $clog2(MAX_SAMPLES);
   localparam int NUM_W = CNT_W + SQ_W;
   localparam int DEN_W = 2 * CNT_W;
   localparam int STEP_W = $clog2(NUM_W + 1);
   localparam int ROOT_W = 16;
   localparam int RAD_W = 2 * ROOT_W;
   localparam int SREM_W = ROOT_W + 1;
   localparam int PNN_W = 14;
   localparam int PNN_SCALE = 10000;
   localparam int Q_DEPTH = 2;
   localparam int QPTR_W = $clog2(Q_DEPTH);
   localparam int QCNT_W = $clog2(Q_DEPTH + 1);
   localparam logic [SAMPLE_W-1:0] THR_RESET = 16'd800;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_BAD   = 2'd2,
      ST_OVF   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_SQRT,
      BK_OUT
   } back_state_type;

   typedef enum logic [1:0] {
      JOB_VAR,
      JOB_RMS,
      JOB_MEAN,
      JOB_PNN
   } job_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] rr_sample;
      logic                sample_bad;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [15:0]      mean_rr;
      logic [15:0]      sdnn;
      logic [15:0]      rmssd;
      logic [PNN_W-1:0] pnn50;
      logic [1:0]       status;
   } rsp_type;

   typedef struct packed {
      status_type       status;
      logic [CNT_W-1:0] n;
      logic [SUM_W-1:0] sum;
      logic [SQ_W-1:0]  sumsq;
      logic [SQ_W-1:0]  dsq;
      logic [CNT_W-1:0] over;
   } rec_type;

endpackage
`default_nettype wire

// File: rtl/hrv_time_domain_stats_core.sv
`default_nettype none
// Time-domain HRV statistics over records of RR intervals (1/16 ms units).
// Request beats carry one interval, a bad-sample flag and a last flag; the
// beat marked last closes the record. Each record yields one response beat
// with the mean, SDNN, RMSSD, pNN50 and a status code.
// Intervals are taken one per cycle; the running sums update in that cycle.
// A closed record enters a two-entry queue; the request side stalls only a
// last beat while that queue is full. The back end then runs a bit-serial
// multiply, four restoring divides and two square roots on one shared
// divider and root unit for each ok record; a record with a nonzero status
// skips these steps and goes straight to the output register. The back end
// works on one record at a time and takes the next queued record only after
// the response of the last one has been loaded into its output register.
// The csr port writes the difference threshold.
// Synchronous reset empties the queue, clears all sums and sets the
// threshold to 800 (50 ms). A stalled response holds in its output register
// while the back end moves to the next queued record.
module hrv_time_domain_stats_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  hrvtds_pkg::req_type               req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output hrvtds_pkg::rsp_type               rsp_data,
   input  logic                              csr_write,
   input  logic [hrvtds_pkg::SAMPLE_W-1:0]   csr_data
);
   import hrvtds_pkg::*;

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   rec_type push_data;
   rec_type pop_data;

   hrvtds_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (push_data)
   );

   hrvtds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (pop_data)
   );

   hrvtds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: rtl/hrvtds_front.sv
`default_nettype none
module hrvtds_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  hrvtds_pkg::req_type               req_data,
   input  logic                              csr_write,
   input  logic [hrvtds_pkg::SAMPLE_W-1:0]   csr_data,
   input  logic                              q_full,
   output logic                              q_push,
   output hrvtds_pkg::rec_type               q_data
);
   import hrvtds_pkg::*;

   logic [SAMPLE_W-1:0] thr_ff, thr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in, cnt_upd;
   logic [SUM_W-1:0]    sum_ff, sum_in, sum_upd;
   logic [SQ_W-1:0]     sq_ff, sq_in, sq_upd;
   logic [SQ_W-1:0]     dsq_ff, dsq_in, dsq_upd;
   logic [CNT_W-1:0]    over_ff, over_in, over_upd;
   logic [SAMPLE_W-1:0] prev_ff, prev_in, prev_upd;
   logic                bad_ff, bad_in, bad_upd;
   logic                ovf_ff, ovf_in, ovf_upd;
   logic                accept;
   logic                full_cnt;
   logic [SAMPLE_W-1:0] x;
   logic [SAMPLE_W-1:0] diff;
   logic [2*SAMPLE_W-1:0] diff_sq;
   logic [2*SAMPLE_W-1:0] x_sq;

   // Only a record end needs a queue slot.
   assign req_stall = q_full && req_data.last;
   assign accept = req_valid && !req_stall;
   assign q_push = accept && req_data.last;

   assign x = req_data.rr_sample;
   assign full_cnt = cnt_ff >= CNT_W'(MAX_SAMPLES);
   assign diff = (x > prev_ff) ? (x - prev_ff) : (prev_ff - x);
   assign diff_sq = diff * diff;
   assign x_sq = x * x;

   always_comb begin
      cnt_upd = cnt_ff;
      sum_upd = sum_ff;
      sq_upd = sq_ff;
      dsq_upd = dsq_ff;
      over_upd = over_ff;
      prev_upd = prev_ff;
      bad_upd = bad_ff;
      ovf_upd = ovf_ff;
      if (full_cnt) begin
         ovf_upd = 1'b1;
      end else begin
         if (req_data.sample_bad) begin
            bad_upd = 1'b1;
         end else begin
            if (cnt_ff != '0) begin
               dsq_upd = dsq_ff + SQ_W'(diff_sq);
               if (diff > thr_ff) begin
                  over_upd = over_ff + CNT_W'(1);
               end
            end
            sum_upd = sum_ff + SUM_W'(x);
            sq_upd = sq_ff + SQ_W'(x_sq);
            prev_upd = x;
         end
         cnt_upd = cnt_ff + CNT_W'(1);
      end
   end

   always_comb begin
      q_data.n = cnt_upd;
      q_data.sum = sum_upd;
      q_data.sumsq = sq_upd;
      q_data.dsq = dsq_upd;
      q_data.over = over_upd;
      priority if (cnt_upd < CNT_W'(2)) begin
         q_data.status = ST_SHORT;
      end else if (bad_upd) begin
         q_data.status = ST_BAD;
      end else if (ovf_upd) begin
         q_data.status = ST_OVF;
      end else begin
         q_data.status = ST_OK;
      end
   end

   always_comb begin
      thr_in = csr_write ? csr_data : thr_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      sq_in = sq_ff;
      dsq_in = dsq_ff;
      over_in = over_ff;
      prev_in = prev_ff;
      bad_in = bad_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (req_data.last) begin
            cnt_in = '0;
            sum_in = '0;
            sq_in = '0;
            dsq_in = '0;
            over_in = '0;
            prev_in = '0;
            bad_in = 1'b0;
            ovf_in = 1'b0;
         end else begin
            cnt_in = cnt_upd;
            sum_in = sum_upd;
            sq_in = sq_upd;
            dsq_in = dsq_upd;
            over_in = over_upd;
            prev_in = prev_upd;
            bad_in = bad_upd;
            ovf_in = ovf_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         cnt_ff <= '0;
         sum_ff <= '0;
         sq_ff <= '0;
         dsq_ff <= '0;
         over_ff <= '0;
         prev_ff <= '0;
         bad_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else begin
         thr_ff <= thr_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         sq_ff <= sq_in;
         dsq_ff <= dsq_in;
         over_ff <= over_in;
         prev_ff <= prev_in;
         bad_ff <= bad_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/hrvtds_queue.sv
`default_nettype none
module hrvtds_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hrvtds_pkg::rec_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output hrvtds_pkg::rec_type pop_data
);
   import hrvtds_pkg::*;

   rec_type             mem_ff [Q_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full = count_ff == QCNT_W'(Q_DEPTH);
   assign empty = count_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/hrvtds_back.sv
`default_nettype none
module hrvtds_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  hrvtds_pkg::rec_type q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hrvtds_pkg::rsp_type rsp_data
);
   import hrvtds_pkg::*;

   back_state_type      state_ff, state_in;
   job_type             job_ff, job_in;
   rec_type             ent_ff, ent_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [NUM_W-1:0]    prod_ff, prod_in;
   logic [CNT_W-1:0]    mb_ff, mb_in;
   logic [2*SUM_W-1:0]  sum2_ff;
   logic [DEN_W-1:0]    nn1_ff;
   logic [CNT_W+PNN_W-1:0] pnum_ff;
   logic [NUM_W-1:0]    dnum_ff, dnum_in;
   logic [DEN_W-1:0]    dden_ff, dden_in;
   logic [DEN_W-1:0]    drem_ff, drem_in;
   logic [RAD_W-1:0]    sx_ff, sx_in;
   logic [SREM_W-1:0]   srem_ff, srem_in;
   logic [ROOT_W-1:0]   sroot_ff, sroot_in;
   logic [15:0]         mean_ff, mean_in;
   logic [15:0]         sdnn_ff, sdnn_in;
   logic [15:0]         rmssd_ff, rmssd_in;
   logic [PNN_W-1:0]    pnn_ff, pnn_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                last_step;
   logic                out_free;
   logic                rsp_load;
   logic [CNT_W-1:0]    nm1;
   logic [DEN_W:0]      div_sh;
   logic                div_ge;
   logic [NUM_W-1:0]    div_num_step;
   logic [DEN_W-1:0]    div_rem_step;
   logic [SREM_W+1:0]   sq_sh;
   logic [SREM_W+1:0]   sq_trial;
   logic                sq_ge;
   logic [SREM_W-1:0]   sq_rem_step;
   logic [ROOT_W-1:0]   sq_root_step;

   assign last_step = step_ff == STEP_W'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign nm1 = ent_ff.n - CNT_W'(1);

   // One restoring divide step: quotient bits shift in where numerator bits leave.
   assign div_sh = {drem_ff, dnum_ff[NUM_W-1]};
   assign div_ge = div_sh >= {1'b0, dden_ff};
   assign div_num_step = {dnum_ff[NUM_W-2:0], div_ge};
   assign div_rem_step = div_ge ? DEN_W'(div_sh - {1'b0, dden_ff}) : div_sh[DEN_W-1:0];

   // One digit-pair square root step.
   assign sq_sh = {srem_ff, sx_ff[RAD_W-1 -: 2]};
   assign sq_trial = (SREM_W+2)'({sroot_ff, 2'b01});
   assign sq_ge = sq_sh >= sq_trial;
   assign sq_rem_step = sq_ge ? SREM_W'(sq_sh - sq_trial) : sq_sh[SREM_W-1:0];
   assign sq_root_step = {sroot_ff[ROOT_W-2:0], sq_ge};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = (q_data.status == ST_OK) ? BK_MUL : BK_OUT;
            end
         end
         BK_MUL: begin
            if (last_step) begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (last_step) begin
               unique case (job_ff)
                  JOB_VAR, JOB_RMS: state_in = BK_SQRT;
                  JOB_MEAN:         state_in = BK_DIV;
                  JOB_PNN:          state_in = BK_OUT;
                  default:          state_in = BK_OUT;
               endcase
            end
         end
         BK_SQRT: begin
            if (last_step) begin
               state_in = BK_DIV;
            end
         end
         BK_OUT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      job_in = job_ff;
      ent_in = ent_ff;
      step_in = step_ff;
      prod_in = prod_ff;
      mb_in = mb_ff;
      dnum_in = dnum_ff;
      dden_in = dden_ff;
      drem_in = drem_ff;
      sx_in = sx_ff;
      srem_in = srem_ff;
      sroot_in = sroot_ff;
      mean_in = mean_ff;
      sdnn_in = sdnn_ff;
      rmssd_in = rmssd_ff;
      pnn_in = pnn_ff;
      q_pop = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               ent_in = q_data;
               prod_in = '0;
               mb_in = q_data.n;
               step_in = STEP_W'(CNT_W);
               mean_in = '0;
               sdnn_in = '0;
               rmssd_in = '0;
               pnn_in = '0;
            end
         end
         BK_MUL: begin
            // N times the sum of squares, one bit of N per cycle.
            prod_in = {prod_ff[NUM_W-2:0], 1'b0}
                    + (mb_ff[CNT_W-1] ? NUM_W'(ent_ff.sumsq) : '0);
            mb_in = {mb_ff[CNT_W-2:0], 1'b0};
            step_in = step_ff - STEP_W'(1);
            if (last_step) begin
               dnum_in = prod_in - NUM_W'(sum2_ff);
               dden_in = nn1_ff;
               drem_in = '0;
               step_in = STEP_W'(NUM_W);
               job_in = JOB_VAR;
            end
         end
         BK_DIV: begin
            dnum_in = div_num_step;
            drem_in = div_rem_step;
            step_in = step_ff - STEP_W'(1);
            if (last_step) begin
               unique case (job_ff)
                  JOB_VAR, JOB_RMS: begin
                     sx_in = div_num_step[RAD_W-1:0];
                     srem_in = '0;
                     sroot_in = '0;
                     step_in = STEP_W'(ROOT_W);
                  end
                  JOB_MEAN: begin
                     mean_in = div_num_step[15:0];
                     dnum_in = NUM_W'(pnum_ff);
                     dden_in = DEN_W'(nm1);
                     drem_in = '0;
                     step_in = STEP_W'(NUM_W);
                     job_in = JOB_PNN;
                  end
                  JOB_PNN: begin
                     pnn_in = div_num_step[PNN_W-1:0];
                  end
                  default: begin
                     pnn_in = '0;
                  end
               endcase
            end
         end
         BK_SQRT: begin
            sx_in = {sx_ff[RAD_W-3:0], 2'b00};
            srem_in = sq_rem_step;
            sroot_in = sq_root_step;
            step_in = step_ff - STEP_W'(1);
            if (last_step) begin
               drem_in = '0;
               step_in = STEP_W'(NUM_W);
               if (job_ff == JOB_VAR) begin
                  sdnn_in = sq_root_step;
                  dnum_in = NUM_W'(ent_ff.dsq);
                  dden_in = DEN_W'(nm1);
                  job_in = JOB_RMS;
               end else begin
                  rmssd_in = sq_root_step;
                  dnum_in = NUM_W'(ent_ff.sum);
                  dden_in = DEN_W'(ent_ff.n);
                  job_in = JOB_MEAN;
               end
            end
         end
         BK_OUT: begin
            rsp_load = out_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.mean_rr = mean_ff;
         rsp_data_in.sdnn = sdnn_ff;
         rsp_data_in.rmssd = rmssd_ff;
         rsp_data_in.pnn50 = pnn_ff;
         rsp_data_in.status = ent_ff.status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      ent_ff <= ent_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
      mb_ff <= mb_in;
      sum2_ff <= ent_ff.sum * ent_ff.sum;
      nn1_ff <= ent_ff.n * nm1;
      pnum_ff <= ent_ff.over * PNN_W'(PNN_SCALE);
      dnum_ff <= dnum_in;
      dden_ff <= dden_in;
      drem_ff <= drem_in;
      sx_ff <= sx_in;
      srem_ff <= srem_in;
      sroot_ff <= sroot_in;
      mean_ff <= mean_in;
      sdnn_ff <= sdnn_in;
      rmssd_ff <= rmssd_in;
      pnn_ff <= pnn_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire
